### hdl/tsst_pkg.sv
// ----------------------------------------------------------------------------
// tsst_pkg
// Types and constants shared by the timestamped sample slot table.
// ----------------------------------------------------------------------------
package tsst_pkg;

   localparam int TIME_BITS = 63;
   localparam int MODE_BITS = 3;
   localparam int STAT_BITS = 3;
   localparam int HNDL_BITS = 3;
   localparam int CFG_BITS  = 4;
   localparam int DATA_BITS = 64;

   localparam logic [MODE_BITS-1:0] MODE_UPDATE  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_LATEST  = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_NEAREST = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_ATMOST  = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_UNLOCK  = 3'd4;
   localparam logic [MODE_BITS-1:0] MODE_WINDOW  = 3'd5;

   localparam logic [STAT_BITS-1:0] ST_OK       = 3'd0;
   localparam logic [STAT_BITS-1:0] ST_NOTFOUND = 3'd1;
   localparam logic [STAT_BITS-1:0] ST_INVALID  = 3'd2;
   localparam logic [STAT_BITS-1:0] ST_INUSE    = 3'd3;
   localparam logic [STAT_BITS-1:0] ST_FAILED   = 3'd4;
   localparam logic [STAT_BITS-1:0] ST_TIMEOUT  = 3'd5;

   localparam logic [DATA_BITS-1:0] NO_TIME = '1;

   // request payload
   typedef struct packed {
      logic [MODE_BITS-1:0] mode;
      logic [TIME_BITS-1:0] query_time;
      logic [TIME_BITS-1:0] window_end;
      logic [DATA_BITS-1:0] new_payload;
      logic [HNDL_BITS-1:0] slot_handle;
   } req_type;

   // response payload
   typedef struct packed {
      logic [STAT_BITS-1:0] status;
      logic [2:0]           matched_slot;
      logic [DATA_BITS-1:0] matched_time;
      logic [DATA_BITS-1:0] matched_payload;
      logic                 sample_valid;
      logic [DATA_BITS-1:0] most_recent;
   } rsp_type;

   // ordering key of a slot: used, time, write order
   function automatic logic key_before(input logic ua, input logic [TIME_BITS-1:0] ta,
                                       input logic [31:0] oa, input logic ub,
                                       input logic [TIME_BITS-1:0] tb,
                                       input logic [31:0] ob);
      if (ua != ub) return !ua;
      if (ua && ta != tb) return ta < tb;
      return oa < ob;
   endfunction

endpackage

### hdl/tsst_if.sv
// ----------------------------------------------------------------------------
// tsst_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface tsst_if #(parameter type payload_type = logic);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### hdl/tsst_cell.sv
// ----------------------------------------------------------------------------
// tsst_cell
// One slot of the table. During a scan it takes the running candidates from
// its left neighbor, merges its own entry in and passes them right.
// ----------------------------------------------------------------------------
module tsst_cell #(
   parameter int LOCK_BITS    = 8,
   parameter int PAYLOAD_BITS = 64,
   parameter int IDX_BITS     = 3
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       active,     // slot index below slots_in_use
   input  logic                       scan,       // this cycle is this cell's turn
   input  logic [IDX_BITS-1:0]        my_idx,
   input  logic [tsst_pkg::TIME_BITS-1:0] qt,
   input  logic [tsst_pkg::TIME_BITS-1:0] we,
   // write back
   input  logic                       wr_en,
   input  logic [tsst_pkg::TIME_BITS-1:0] wr_time,
   input  logic [PAYLOAD_BITS-1:0]    wr_data,
   input  logic [31:0]                wr_order,
   input  logic                       lk_inc,
   input  logic                       lk_dec,
   // own state
   output logic                       used,
   output logic [tsst_pkg::TIME_BITS-1:0] stime,
   output logic [PAYLOAD_BITS-1:0]    sdata,
   output logic [LOCK_BITS-1:0]       locks,
   // candidate chain: 0 update, 1 max all, 2 min filled>=qt, 3 max below qt,
   // 4 max atmost qt, 5 max filled atmost we, 6 max filled locked
   input  logic [6:0]                 hv_i,
   input  logic [6:0][IDX_BITS-1:0]   hi_i,
   input  logic [6:0]                 hu_i,
   input  logic [6:0][tsst_pkg::TIME_BITS-1:0] ht_i,
   input  logic [6:0][31:0]           ho_i,
   output logic [6:0]                 hv_o,
   output logic [6:0][IDX_BITS-1:0]   hi_o,
   output logic [6:0]                 hu_o,
   output logic [6:0][tsst_pkg::TIME_BITS-1:0] ht_o,
   output logic [6:0][31:0]           ho_o
);
   import tsst_pkg::*;

   logic                 used_ff, used_in;
   logic [TIME_BITS-1:0] time_ff;
   logic [PAYLOAD_BITS-1:0] data_ff;
   logic [LOCK_BITS-1:0] locks_ff, locks_in;
   logic [31:0]          order_ff;
   logic [6:0]           sel;
   logic [6:0]           wmax;

   assign used = used_ff;
   assign stime = time_ff;
   assign sdata = data_ff;
   assign locks = locks_ff;

   always_comb begin
      sel[0] = !used_ff || locks_ff == '0;
      sel[1] = 1'b1;
      sel[2] = used_ff && time_ff >= qt;
      sel[3] = !used_ff || time_ff < qt;
      sel[4] = !used_ff || time_ff <= qt;
      sel[5] = used_ff && time_ff <= we;
      sel[6] = used_ff && locks_ff != '0;
      wmax = 7'b1111010;
      for (int k = 0; k < 7; k++) begin
         hv_o[k] = hv_i[k]; hi_o[k] = hi_i[k]; hu_o[k] = hu_i[k];
         ht_o[k] = ht_i[k]; ho_o[k] = ho_i[k];
         if (scan && active && sel[k] && (!hv_i[k] ||
             (wmax[k] ? key_before(hu_i[k], ht_i[k], ho_i[k], used_ff, time_ff, order_ff)
                      : key_before(used_ff, time_ff, order_ff, hu_i[k], ht_i[k], ho_i[k]))))
         begin
            hv_o[k] = 1'b1; hi_o[k] = my_idx; hu_o[k] = used_ff;
            ht_o[k] = time_ff; ho_o[k] = order_ff;
         end
      end
   end

   always_comb begin
      used_in = used_ff;
      locks_in = locks_ff;
      if (wr_en) used_in = 1'b1;
      if (lk_inc && locks_ff != '1) locks_in = locks_ff + 1'b1;
      if (lk_dec) locks_in = locks_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         used_ff  <= 1'b0;
         locks_ff <= '0;
         order_ff <= 32'(my_idx);
      end else begin
         used_ff  <= used_in;
         locks_ff <= locks_in;
         if (wr_en) order_ff <= wr_order;
      end
      if (wr_en) begin
         time_ff <= wr_time;
         data_ff <= wr_data;
      end
   end

endmodule

### hdl/timestamped_sample_slot_table.sv
// ----------------------------------------------------------------------------
// timestamped_sample_slot_table
// Slot table with update, lock by time, unlock and window check.
// ----------------------------------------------------------------------------
// Flow: the scan steps one cell of the slot chain per cycle, then one
// decide/write-back state, a response state held until the response is
// taken, and an idle state; a new request is accepted only when idle.
// Reset: all slots empty, lock counts zero, slots_in_use = SLOT_COUNT capped at 8.
// A csr write clears the store in the same cycle.
module timestamped_sample_slot_table #(
   parameter int SLOT_COUNT   = 8,
   parameter int PAYLOAD_BITS = 64,
   parameter int LOCK_BITS    = 8
) (
   input  logic clock,
   input  logic reset,
   tsst_if.sink   req,
   tsst_if.source rsp,
   input  logic   csr_we,
   input  logic [tsst_pkg::CFG_BITS-1:0] csr_wdata
);
   import tsst_pkg::*;

   localparam int IB = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int CB = $clog2(SLOT_COUNT + 1);
   localparam logic [1:0] S_IDLE = 2'd0, S_SCAN = 2'd1, S_DEC = 2'd2, S_OUT = 2'd3;

   logic [1:0]    state_ff;
   logic [CB-1:0] cnt_ff;
   logic [CB-1:0] siu_ff;
   logic          ever_ff;
   logic [31:0]   nord_ff;
   req_type       rq_ff;
   rsp_type       rs_ff;

   logic [SLOT_COUNT:0][6:0]              hv;
   logic [SLOT_COUNT:0][6:0][IB-1:0]      hi;
   logic [SLOT_COUNT:0][6:0]              hu;
   logic [SLOT_COUNT:0][6:0][TIME_BITS-1:0] ht;
   logic [SLOT_COUNT:0][6:0][31:0]        ho;
   logic [6:0]                  cv_ff;
   logic [6:0][IB-1:0]          ci_ff;
   logic [6:0]                  cu_ff;
   logic [6:0][TIME_BITS-1:0]   ct_ff;
   logic [6:0][31:0]            co_ff;

   logic [SLOT_COUNT-1:0]                 used;
   logic [SLOT_COUNT-1:0][TIME_BITS-1:0]  stime;
   logic [SLOT_COUNT-1:0][PAYLOAD_BITS-1:0] sdata;
   logic [SLOT_COUNT-1:0][LOCK_BITS-1:0]  locks;
   logic [SLOT_COUNT-1:0] wr_en, lk_inc, lk_dec;

   // decide
   logic          hit_v;
   logic [IB-1:0] hit;
   logic [STAT_BITS-1:0] st;
   logic [TIME_BITS-1:0] qt, we;

   assign qt = rq_ff.query_time;
   assign we = rq_ff.window_end;
   assign req.ready = (state_ff == S_IDLE);
   assign rsp.valid = (state_ff == S_OUT);
   assign rsp.data  = rs_ff;

   // chain input: the registered candidates run past one cell per cycle
   assign hv[0] = cv_ff; assign hi[0] = ci_ff; assign hu[0] = cu_ff;
   assign ht[0] = ct_ff; assign ho[0] = co_ff;

   for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
      tsst_cell #(.LOCK_BITS(LOCK_BITS), .PAYLOAD_BITS(PAYLOAD_BITS), .IDX_BITS(IB)) u_cell (
         .clock, .reset, .clear(csr_we),
         .active(CB'(g) < siu_ff),
         .scan(state_ff == S_SCAN && cnt_ff == CB'(g)),
         .my_idx(IB'(g)), .qt, .we,
         .wr_en(wr_en[g]), .wr_time(qt), .wr_data(rq_ff.new_payload[PAYLOAD_BITS-1:0]),
         .wr_order(nord_ff), .lk_inc(lk_inc[g]), .lk_dec(lk_dec[g]),
         .used(used[g]), .stime(stime[g]), .sdata(sdata[g]), .locks(locks[g]),
         .hv_i(hv[g]), .hi_i(hi[g]), .hu_i(hu[g]), .ht_i(ht[g]), .ho_i(ho[g]),
         .hv_o(hv[g+1]), .hi_o(hi[g+1]), .hu_o(hu[g+1]), .ht_o(ht[g+1]), .ho_o(ho[g+1])
      );
   end

   logic hd_ok;
   always_comb begin
      hit_v = 1'b0; hit = '0; st = ST_OK;
      hd_ok = 32'(rq_ff.slot_handle) < 32'(siu_ff) &&
              32'(rq_ff.slot_handle) < 32'(SLOT_COUNT);
      unique case (rq_ff.mode)
         MODE_UPDATE: begin
            hit_v = cv_ff[0]; hit = ci_ff[0];
            if (!cv_ff[0]) st = ST_INUSE;
         end
         MODE_LATEST: begin hit_v = cv_ff[1]; hit = ci_ff[1]; end
         MODE_NEAREST: begin
            hit_v = 1'b1;
            if (!cv_ff[2]) hit = ci_ff[1];
            else if (ct_ff[2] == qt || !cv_ff[3] || !cu_ff[3]) hit = ci_ff[2];
            else if (ct_ff[2] - qt <= qt - ct_ff[3]) hit = ci_ff[2];
            else hit = ci_ff[3];
         end
         MODE_ATMOST: begin
            hit_v = cv_ff[4]; hit = ci_ff[4];
            if (!cv_ff[4]) st = ST_NOTFOUND;
         end
         MODE_UNLOCK: begin
            if (!hd_ok) st = ST_INVALID;
            else if (locks[rq_ff.slot_handle[IB-1:0]] == '0) st = ST_FAILED;
         end
         MODE_WINDOW: begin
            if (qt > we) st = ST_INVALID;
            else if (!cu_ff[1] || ct_ff[1] < qt) st = ST_TIMEOUT;
            else if (ct_ff[1] <= we) st = ST_OK;
            else st = (cv_ff[5] && ct_ff[5] >= qt) ? ST_OK : ST_FAILED;
         end
         default: st = ST_INVALID;
      endcase
   end

   always_comb begin
      wr_en = '0; lk_inc = '0; lk_dec = '0;
      if (state_ff == S_DEC) begin
         if (rq_ff.mode == MODE_UPDATE && hit_v) wr_en[hit] = 1'b1;
         if ((rq_ff.mode == MODE_LATEST || rq_ff.mode == MODE_NEAREST ||
              rq_ff.mode == MODE_ATMOST) && hit_v) lk_inc[hit] = 1'b1;
         if (rq_ff.mode == MODE_UNLOCK && st == ST_OK) lk_dec[rq_ff.slot_handle[IB-1:0]] = 1'b1;
      end
   end

   // most recent after the operation. An update either lands on a slot below
   // the newest, or overwrites the newest itself; in that case every other
   // slot is filled and locked, so the newest locked slot competes with it.
   logic [DATA_BITS-1:0] mr;
   logic                 lock_hit;
   always_comb begin
      mr = cu_ff[1] ? {1'b0, ct_ff[1]} : NO_TIME;
      if (rq_ff.mode == MODE_UPDATE && hit_v) begin
         if (!cu_ff[1] || qt >= ct_ff[1]) mr = {1'b0, qt};
         else if (ci_ff[1] == hit)
            mr = (cv_ff[6] && ct_ff[6] > qt) ? {1'b0, ct_ff[6]} : {1'b0, qt};
      end
      lock_hit = hit_v && (rq_ff.mode == MODE_LATEST || rq_ff.mode == MODE_NEAREST ||
                           rq_ff.mode == MODE_ATMOST);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         siu_ff   <= CB'(SLOT_COUNT < 8 ? SLOT_COUNT : 8);
         ever_ff  <= 1'b0;
         nord_ff  <= 32'(SLOT_COUNT);
         cnt_ff   <= '0;
      end else begin
         if (csr_we) begin
            if (csr_wdata == '0) siu_ff <= CB'(1);
            else if (32'(csr_wdata) > 32'(SLOT_COUNT)) siu_ff <= CB'(SLOT_COUNT);
            else siu_ff <= CB'(csr_wdata);
            ever_ff <= 1'b0;
            nord_ff <= 32'(SLOT_COUNT);
         end
         unique case (state_ff)
            S_IDLE: if (req.valid) begin
               state_ff <= S_SCAN; cnt_ff <= '0;
            end
            S_SCAN: begin
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CB'(SLOT_COUNT - 1)) state_ff <= S_DEC;
            end
            S_DEC: begin
               state_ff <= S_OUT;
               if (rq_ff.mode == MODE_UPDATE && hit_v) begin
                  ever_ff <= 1'b1; nord_ff <= nord_ff + 1'b1;
               end
            end
            S_OUT: if (rsp.ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
      if (state_ff == S_IDLE && req.valid) rq_ff <= req.data;
      if (state_ff == S_IDLE) cv_ff <= '0;
      if (state_ff == S_SCAN) begin
         cv_ff <= hv[SLOT_COUNT]; ci_ff <= hi[SLOT_COUNT]; cu_ff <= hu[SLOT_COUNT];
         ct_ff <= ht[SLOT_COUNT]; co_ff <= ho[SLOT_COUNT];
      end
      if (state_ff == S_DEC) begin
         rs_ff.status <= st;
         rs_ff.most_recent <= mr;
         if ((rq_ff.mode == MODE_UPDATE && hit_v) || lock_hit) begin
            rs_ff.matched_slot <= 3'(hit);
            if (rq_ff.mode == MODE_UPDATE) begin
               rs_ff.matched_time    <= {1'b0, qt};
               rs_ff.matched_payload <= 64'(rq_ff.new_payload[PAYLOAD_BITS-1:0]);
               rs_ff.sample_valid    <= 1'b1;
            end else begin
               rs_ff.matched_time    <= used[hit] ? {1'b0, stime[hit]} : NO_TIME;
               rs_ff.matched_payload <= used[hit] ? 64'(sdata[hit]) : '0;
               rs_ff.sample_valid    <= ever_ff;
            end
         end else begin
            rs_ff.matched_slot <= '0; rs_ff.matched_time <= NO_TIME;
            rs_ff.matched_payload <= '0; rs_ff.sample_valid <= 1'b0;
         end
      end
   end

   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      !(req.ready && rsp.valid)) else $error("ready while response pending");
   a_scan_len: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DEC |-> $past(state_ff) == S_SCAN) else $error("short scan");
   a_one_write: assert property (@(posedge clock) disable iff (reset)
      $onehot0(wr_en) && $onehot0(lk_inc) && $onehot0(lk_dec)) else $error("multi write");

endmodule

### bench/tsst_checker.sv
// ----------------------------------------------------------------------------
// tsst_checker
// Watches the request and response channels of the slot table, keeps its own
// model of the slots and compares every response with the predicted one.
// ----------------------------------------------------------------------------
module tsst_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  tsst_pkg::req_type req_data,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  tsst_pkg::rsp_type rsp_data,
   input  logic csr_we,
   input  logic [tsst_pkg::CFG_BITS-1:0] csr_wdata,
   output int   fail_count,
   output int   pending
);
   import tsst_pkg::*;

   localparam int NSLOT = 8;
   localparam int LOCK_MAX = 255;

   int unsigned          active_slots;
   logic                 used [NSLOT];
   logic [TIME_BITS-1:0] stamp [NSLOT];
   logic [DATA_BITS-1:0] data [NSLOT];
   int unsigned          locks [NSLOT];
   longint unsigned      order [NSLOT];
   longint unsigned      next_order;
   logic                 ever_updated;

   rsp_type expected_rsp [$];

   assign pending = expected_rsp.size();

   task automatic clear_slots();
      for (int i = 0; i < NSLOT; i++) begin
         used[i] = 1'b0;
         stamp[i] = '0;
         data[i] = '0;
         locks[i] = 0;
         order[i] = i;
      end
      next_order = NSLOT;
      ever_updated = 1'b0;
   endtask

   function automatic bit older(int a, int b);
      if (used[a] != used[b]) return !used[a];
      if (used[a] && stamp[a] != stamp[b]) return stamp[a] < stamp[b];
      return order[a] < order[b];
   endfunction

   // sel: 0 all, 1 filled >= t, 2 empty or < t, 3 empty or <= t, 4 filled <= t
   function automatic int pick_slot(int sel, logic [TIME_BITS-1:0] t, bit newest);
      int best;
      bit ok;
      best = -1;
      for (int i = 0; i < int'(active_slots); i++) begin
         case (sel)
            1: ok = used[i] && stamp[i] >= t;
            2: ok = !used[i] || stamp[i] < t;
            3: ok = !used[i] || stamp[i] <= t;
            4: ok = used[i] && stamp[i] <= t;
            default: ok = 1;
         endcase
         if (ok && (best < 0 || (newest ? older(best, i) : older(i, best))))
            best = i;
      end
      return best;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type o;
      int hit, up, lo, top, b;
      bit hit_ok;
      hit = -1;
      hit_ok = 0;
      o.status = ST_OK;
      case (r.mode)
         MODE_UPDATE: begin
            for (int i = 0; i < int'(active_slots); i++)
               if (!(used[i] && locks[i] != 0) && (hit < 0 || older(i, hit))) hit = i;
            if (hit < 0) o.status = ST_INUSE;
            else begin
               used[hit] = 1'b1;
               stamp[hit] = r.query_time;
               data[hit] = r.new_payload;
               order[hit] = next_order++;
               ever_updated = 1'b1;
               hit_ok = 1;
            end
         end
         MODE_LATEST, MODE_NEAREST, MODE_ATMOST: begin
            if (r.mode == MODE_LATEST) hit = pick_slot(0, '0, 1);
            else if (r.mode == MODE_NEAREST) begin
               up = pick_slot(1, r.query_time, 0);
               if (up < 0) hit = pick_slot(0, '0, 1);
               else if (stamp[up] == r.query_time) hit = up;
               else begin
                  lo = pick_slot(2, r.query_time, 1);
                  if (lo < 0 || !used[lo]) hit = up;
                  else if (stamp[up] - r.query_time <= r.query_time - stamp[lo]) hit = up;
                  else hit = lo;
               end
            end else hit = pick_slot(3, r.query_time, 1);
            if (hit < 0) o.status = ST_NOTFOUND;
            else begin
               if (locks[hit] < LOCK_MAX) locks[hit]++;
               hit_ok = 1;
            end
         end
         MODE_UNLOCK: begin
            if (r.slot_handle >= active_slots) o.status = ST_INVALID;
            else if (locks[r.slot_handle] > 0) locks[r.slot_handle]--;
            else o.status = ST_FAILED;
         end
         MODE_WINDOW: begin
            if (r.query_time > r.window_end) o.status = ST_INVALID;
            else begin
               top = pick_slot(0, '0, 1);
               if (top < 0 || !used[top] || stamp[top] < r.query_time) o.status = ST_TIMEOUT;
               else if (stamp[top] <= r.window_end) o.status = ST_OK;
               else begin
                  b = pick_slot(4, r.window_end, 1);
                  o.status = (b >= 0 && stamp[b] >= r.query_time) ? ST_OK : ST_FAILED;
               end
            end
         end
         default: o.status = ST_INVALID;
      endcase
      if (hit >= 0 && hit_ok) begin
         o.matched_slot = hit[2:0];
         o.matched_time = used[hit] ? {1'b0, stamp[hit]} : NO_TIME;
         o.matched_payload = used[hit] ? data[hit] : '0;
         o.sample_valid = ever_updated;
      end else begin
         o.matched_slot = '0;
         o.matched_time = NO_TIME;
         o.matched_payload = '0;
         o.sample_valid = 1'b0;
      end
      top = pick_slot(0, '0, 1);
      o.most_recent = (top >= 0 && used[top]) ? {1'b0, stamp[top]} : NO_TIME;
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   initial begin
      fail_count = 0;
      active_slots = NSLOT;
      clear_slots();
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         active_slots = NSLOT;
         clear_slots();
         expected_rsp.delete();
      end else begin
         if (csr_we) begin
            active_slots = (csr_wdata == 0) ? 1 : (csr_wdata > NSLOT ? NSLOT : csr_wdata);
            clear_slots();
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0)
               report_mismatch("unexpected transaction", 64'(rsp_data.status), 64'(0));
            else begin
               want = expected_rsp.pop_front();
               if (rsp_data.status !== want.status)
                  report_mismatch("status", 64'(rsp_data.status), 64'(want.status));
               if (rsp_data.matched_slot !== want.matched_slot)
                  report_mismatch("matched_slot", 64'(rsp_data.matched_slot),
                                  64'(want.matched_slot));
               if (rsp_data.matched_time !== want.matched_time)
                  report_mismatch("matched_time", rsp_data.matched_time, want.matched_time);
               if (rsp_data.matched_payload !== want.matched_payload)
                  report_mismatch("matched_payload", rsp_data.matched_payload,
                                  want.matched_payload);
               if (rsp_data.sample_valid !== want.sample_valid)
                  report_mismatch("sample_valid", 64'(rsp_data.sample_valid),
                                  64'(want.sample_valid));
               if (rsp_data.most_recent !== want.most_recent)
                  report_mismatch("most_recent", rsp_data.most_recent, want.most_recent);
            end
         end
         if (req_valid && req_ready)
            expected_rsp.push_back(apply_request(req_data));
      end
   end

endmodule

### bench/tb_timestamped_sample_slot_table.sv
// ----------------------------------------------------------------------------
// tb_timestamped_sample_slot_table
// Drives directed and random slot table operations across several table
// sizes with random idling on both channels; the checker judges responses.
// ----------------------------------------------------------------------------
module tb_timestamped_sample_slot_table;
   import tsst_pkg::*;

   localparam longint CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CFG_BITS-1:0] csr_wdata = '0;
   int   fail_count;
   int   pending;
   longint cycles = 0;
   bit   no_idle = 0;

   tsst_if #(.payload_type(req_type)) req_ch ();
   tsst_if #(.payload_type(rsp_type)) rsp_ch ();

   timestamped_sample_slot_table dut (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch),
      .csr_we(csr_we), .csr_wdata(csr_wdata)
   );

   tsst_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_ch.valid), .req_ready(req_ch.ready), .req_data(req_ch.data),
      .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready), .rsp_data(rsp_ch.data),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending(pending)
   );

   always #2 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   always @(posedge clock)
      rsp_ch.ready <= no_idle || ($urandom_range(99) >= 27);

   // small time pool so ties, exact hits and neighbors happen often
   function automatic logic [TIME_BITS-1:0] pick_time();
      case ($urandom_range(9))
         0: return '1;
         1: return '0;
         2: return TIME_BITS'({$urandom, $urandom});
         default: return TIME_BITS'(100 + $urandom_range(40));
      endcase
   endfunction

   // valid drops after each transaction; the block is busy then
   task automatic send(req_type r);
      while (!no_idle && $urandom_range(99) < 27) @(posedge clock);
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      do @(posedge clock); while (!req_ch.ready);
      req_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_op(logic [MODE_BITS-1:0] m, logic [TIME_BITS-1:0] qt,
                          logic [TIME_BITS-1:0] we, logic [HNDL_BITS-1:0] h);
      req_type r;
      r.mode = m;
      r.query_time = qt;
      r.window_end = we;
      r.new_payload = {$urandom, $urandom};
      r.slot_handle = h;
      send(r);
   endtask

   task automatic drain();
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_size(logic [CFG_BITS-1:0] v);
      drain();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic random_ops(int n);
      req_type r;
      int k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(99);
         r.mode = k < 30 ? MODE_UPDATE : k < 40 ? MODE_LATEST : k < 52 ? MODE_NEAREST :
                  k < 62 ? MODE_ATMOST : k < 82 ? MODE_UNLOCK : k < 96 ? MODE_WINDOW :
                  3'(6 + $urandom_range(1));
         r.query_time = pick_time();
         r.window_end = ($urandom_range(3) == 0) ? pick_time() : r.query_time + $urandom_range(20);
         r.new_payload = {$urandom, $urandom};
         r.slot_handle = HNDL_BITS'($urandom_range(7));
         send(r);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, every mode
      send_op(MODE_LATEST, '0, '0, '0);
      send_op(MODE_NEAREST, 50, '0, '0);
      send_op(MODE_ATMOST, 50, '0, '0);
      send_op(MODE_WINDOW, 10, 20, '0);
      send_op(MODE_WINDOW, 30, 20, '0);
      send_op(MODE_UNLOCK, '0, '0, 3'd7);
      send_op(MODE_UNLOCK, '0, '0, 3'd1);
      send_op(3'd6, '1, '1, '0);
      send_op(3'd7, '0, '0, 3'd7);
      send_op(MODE_UPDATE, '1, '1, '0);
      send_op(MODE_UPDATE, 100, '0, '0);
      send_op(MODE_UPDATE, 110, '0, '0);
      send_op(MODE_UPDATE, 110, '0, '0);
      send_op(MODE_NEAREST, 105, '0, '0);
      send_op(MODE_ATMOST, 50, '0, '0);
      send_op(MODE_ATMOST, 109, '0, '0);
      send_op(MODE_WINDOW, 101, 109, '0);
      send_op(MODE_WINDOW, 100, 110, '0);
      drain();

      // saturate a lock count, then fill a single-slot table
      write_size(4'd1);
      no_idle = 1;
      repeat (260) send_op(MODE_LATEST, '0, '0, '0);
      send_op(MODE_UPDATE, 5, '0, '0);
      send_op(MODE_UNLOCK, '0, '0, 3'd0);
      send_op(MODE_UNLOCK, '0, '0, 3'd1);
      no_idle = 0;

      write_size(4'd0);
      random_ops(60);
      write_size(4'd15);
      random_ops(150);
      no_idle = 1;
      random_ops(150);
      no_idle = 0;
      write_size(4'd3);
      random_ops(150);
      write_size(4'd8);
      random_ops(150);
      drain();
      random_ops(100);

      drain();
      if (fail_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
